>>> design/uvs_pkg.sv
// Package with the shared types, constants and tables of the UV sphere generator.
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;

  localparam int unsigned MaxDivisions = 1023;
  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned DivBits      = 10;
  localparam int unsigned QuotBits     = 32;
  localparam int unsigned IdxBits      = 21;
  localparam int unsigned RadBits      = 16;
  localparam int unsigned TexBits      = 17;
  localparam int unsigned NrmBits      = 16;
  localparam int unsigned CwBits       = 34;

  localparam logic signed [CwBits-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [IdxBits-1:0] PosLim = 21'sd1048575;
  localparam logic signed [NrmBits-1:0] NrmLim = 16'sd16384;

  localparam logic [1:0] KindVertex   = 2'd0;
  localparam logic [1:0] KindTriangle = 2'd1;
  localparam logic [1:0] KindError    = 2'd2;

  localparam logic [1:0] CfgSectors = 2'd0;
  localparam logic [1:0] CfgStacks  = 2'd1;
  localparam logic [1:0] CfgRadius  = 2'd2;

  function automatic logic signed [CwBits-1:0] atan_turn(input logic [4:0] k);
    logic signed [CwBits-1:0] r;
    case (k)
      5'd0:  r = 34'sh20000000;
      5'd1:  r = 34'sh12E4051E;
      5'd2:  r = 34'sh09FB385B;
      5'd3:  r = 34'sh051111D4;
      5'd4:  r = 34'sh028B0D43;
      5'd5:  r = 34'sh0145D7E1;
      5'd6:  r = 34'sh00A2F61E;
      5'd7:  r = 34'sh00517C55;
      5'd8:  r = 34'sh0028BE53;
      5'd9:  r = 34'sh00145F2F;
      5'd10: r = 34'sh000A2F98;
      5'd11: r = 34'sh000517CC;
      5'd12: r = 34'sh00028BE6;
      5'd13: r = 34'sh000145F3;
      5'd14: r = 34'sh0000A2FA;
      5'd15: r = 34'sh0000517D;
      5'd16: r = 34'sh000028BE;
      5'd17: r = 34'sh0000145F;
      5'd18: r = 34'sh00000A30;
      5'd19: r = 34'sh00000518;
      5'd20: r = 34'sh0000028C;
      5'd21: r = 34'sh00000146;
      5'd22: r = 34'sh000000A3;
      5'd23: r = 34'sh00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Divider cell payload: one quotient bit per cell, restoring.
  typedef struct packed {
    logic [DivBits:0]   rem;
    logic [QuotBits-1:0] num;
    logic [QuotBits-1:0] quo;
  } div_word_t;

  // Rotation cell payload.
  typedef struct packed {
    logic signed [CwBits-1:0] x;
    logic signed [CwBits-1:0] y;
    logic signed [CwBits-1:0] z;
  } rot_word_t;

endpackage
`default_nettype wire

>>> design/uvs_div_cell.sv
// One restoring divider cell: produces one quotient bit and passes the word on.
`timescale 1ns / 1ps
`default_nettype none
module uvs_div_cell
  import uvs_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic [DivBits-1:0] den_i,
  input  wire div_word_t      word_i,
  output div_word_t           word_o
);
  div_word_t word_d, word_q;
  logic [DivBits+1:0] trial;

  always_comb begin
    trial = {word_i.rem, word_i.num[QuotBits-1]};
    word_d.num = {word_i.num[QuotBits-2:0], 1'b0};
    if (trial >= {2'b00, den_i}) begin
      word_d.rem = DivBits'(trial - {2'b00, den_i}) == '0 ? '0 :
                   (DivBits+1)'(trial - {2'b00, den_i});
      word_d.quo = {word_i.quo[QuotBits-2:0], 1'b1};
    end else begin
      word_d.rem = (DivBits+1)'(trial);
      word_d.quo = {word_i.quo[QuotBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end
  assign word_o = word_q;
endmodule
`default_nettype wire

>>> design/uvs_rot_cell.sv
// One CORDIC rotation cell: a fixed shift step that passes the vector on.
`timescale 1ns / 1ps
`default_nettype none
module uvs_rot_cell
  import uvs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic [4:0] step_i,
  input  wire rot_word_t word_i,
  output rot_word_t      word_o
);
  rot_word_t word_d, word_q;
  logic signed [CwBits-1:0] dx, dy, at;

  always_comb begin
    dx = word_i.y >>> step_i;
    dy = word_i.x >>> step_i;
    at = atan_turn(step_i);
    if (!word_i.z[CwBits-1]) begin
      word_d.x = word_i.x - dx;
      word_d.y = word_i.y + dy;
      word_d.z = word_i.z - at;
    end else begin
      word_d.x = word_i.x + dx;
      word_d.y = word_i.y - dy;
      word_d.z = word_i.z + at;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end
  assign word_o = word_q;
endmodule
`default_nettype wire

>>> design/uv_sphere_mesh_generator.sv
// Top level of the UV sphere generator: divider and CORDIC cell chains, then the output.
//
// A point enters through start_i while busy_o is low; busy_o keeps room for the three
// result words of an interior point before a new point is taken. The point
// flows through two chains of 32 divider cells (the phase quotients), one phase setup
// stage, 16 CORDIC cells, then four multiply and rounding stages, after which its
// vertex word is on the outputs. busy_o goes high once a point is accepted and stays
// high until the gap counter has run down, giving each point its own issue window.
// Results are one-cycle strobes on valid_o and cannot be held off. Out-of-range points
// give one error word on the same schedule.
`timescale 1ns / 1ps
`default_nettype none
module uv_sphere_mesh_generator
  import uvs_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic [DivBits-1:0]       stack_index_i,
  input  wire logic [DivBits-1:0]       sector_index_i,
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_index_i,
  input  wire logic [RadBits-1:0]       cfg_data_i,
  output logic                          valid_o,
  output logic [1:0]                    kind_o,
  output logic                          last_o,
  output logic signed [IdxBits-1:0]     word_a_o,
  output logic signed [IdxBits-1:0]     word_b_o,
  output logic signed [IdxBits-1:0]     word_c_o,
  output logic signed [NrmBits-1:0]     normal_x_o,
  output logic signed [NrmBits-1:0]     normal_y_o,
  output logic signed [NrmBits-1:0]     normal_z_o,
  output logic [TexBits-1:0]            tex_u_o,
  output logic [TexBits-1:0]            tex_v_o
);
  localparam int unsigned DivCells = QuotBits;
  localparam int unsigned Depth = DivCells + 1 + CordicSteps + 4;

  logic [DivBits-1:0] sec_q, stk_q;
  logic [RadBits-1:0] rad_q;
  logic [1:0] gap_q;
  logic go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q <= 10'd36;
      stk_q <= 10'd18;
      rad_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgSectors: sec_q <= cfg_data_i[DivBits-1:0];
        CfgStacks:  stk_q <= cfg_data_i[DivBits-1:0];
        CfgRadius:  rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DivBits-1:0] s_cnt, t_cnt;
  assign s_cnt = (sec_q < 10'd3) ? 10'd3 : sec_q;
  assign t_cnt = (stk_q < 10'd2) ? 10'd2 : stk_q;

  assign go = start_i && !busy_o;
  assign busy_o = gap_q != 2'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) gap_q <= 2'd0;
    else if (go) gap_q <= 2'd2;
    else if (gap_q != 2'd0) gap_q <= gap_q - 2'd1;
  end

  // Sideband travels alongside the cells.
  typedef struct packed {
    logic               err;
    logic [DivBits-1:0] i;
    logic [DivBits-1:0] j;
  } side_t;
  side_t side_q [Depth];
  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else vld_q <= {vld_q[Depth-2:0], go};
  end
  always_ff @(posedge clk_i) begin
    side_q[0] <= '{err: (stack_index_i > t_cnt) || (sector_index_i > s_cnt),
                   i: stack_index_i, j: sector_index_i};
    for (int n = 1; n < Depth; n++) side_q[n] <= side_q[n-1];
  end

  // Two divider chains: j*2^32/S and i*2^31/T, with half the divisor added.
  // The high numerator part is the starting remainder; the low part holds half the divisor (plus i&1 at bit 31 for T).
  div_word_t lo_w [DivCells+1];
  div_word_t la_w [DivCells+1];
  // A point on the seam column (j equal to S) wraps to phase zero.
  assign lo_w[0] = '{rem: (sector_index_i == s_cnt) ? '0 : {1'b0, sector_index_i},
                     num: {22'd0, s_cnt >> 1},
                     quo: '0};
  // i*2^31 = (i>>1)*2^32 + (i&1)*2^31; with i <= T the remainder i>>1 stays below T.
  assign la_w[0] = '{rem: {2'b00, stack_index_i[DivBits-1:1]},
                     num: {stack_index_i[0], 31'd0} + {22'd0, t_cnt >> 1},
                     quo: '0};
  for (genvar g = 0; g < DivCells; g++) begin : g_div
    uvs_div_cell u_lo (.clk_i(clk_i), .den_i(s_cnt), .word_i(lo_w[g]),
                       .word_o(lo_w[g+1]));
    uvs_div_cell u_la (.clk_i(clk_i), .den_i(t_cnt), .word_i(la_w[g]),
                       .word_o(la_w[g+1]));
  end

  // Texture coordinates come from the top 16 quotient bits plus a rounding bit.
  // Phase setup stage.
  logic [31:0] lon_ph, lat_ph;
  assign lon_ph = lo_w[DivCells].quo;
  assign lat_ph = 32'h4000_0000 - la_w[DivCells].quo;
  rot_word_t lo_r [CordicSteps+1];
  rot_word_t la_r [CordicSteps+1];
  logic [TexBits-1:0] tu_q, tv_q;
  logic neg_lo_q, neg_la_q;
  function automatic rot_word_t setup(input logic [31:0] ph, output logic neg);
    logic [31:0] p;
    rot_word_t w;
    neg = ph[31] ^ ph[30];
    p = neg ? ph + 32'h8000_0000 : ph;
    w.x = CordicGain;
    w.y = '0;
    w.z = {{2{p[31]}}, p};
    return w;
  endfunction
  rot_word_t lo_s, la_s, lo_s_q, la_s_q;
  logic nl, na;
  always_comb begin
    lo_s = setup(lon_ph, nl);
    la_s = setup(lat_ph, na);
  end
  always_ff @(posedge clk_i) begin
    lo_s_q <= lo_s;
    la_s_q <= la_s;
    tu_q <= (side_q[DivCells-1].j == s_cnt) ? 17'h10000 :
            {1'b0, lo_w[DivCells].quo[31:16]} + 17'(lo_w[DivCells].quo[15]);
    tv_q <= (side_q[DivCells-1].i == t_cnt) ? 17'h10000 :
            {1'b0, la_w[DivCells].quo[30:15]} + 17'(la_w[DivCells].quo[14]);
    neg_lo_q <= nl;
    neg_la_q <= na;
  end
  assign lo_r[0] = lo_s_q;
  assign la_r[0] = la_s_q;
  logic [TexBits-1:0] tu_p [CordicSteps+1];
  logic [TexBits-1:0] tv_p [CordicSteps+1];
  logic nlo_p [CordicSteps+1];
  logic nla_p [CordicSteps+1];
  assign tu_p[0] = tu_q;
  assign tv_p[0] = tv_q;
  assign nlo_p[0] = neg_lo_q;
  assign nla_p[0] = neg_la_q;
  for (genvar g = 0; g < CordicSteps; g++) begin : g_rot
    logic [TexBits-1:0] tu_stage_q, tv_stage_q;
    logic nlo_stage_q, nla_stage_q;
    uvs_rot_cell u_lo (.clk_i(clk_i), .step_i(5'(g)), .word_i(lo_r[g]),
                       .word_o(lo_r[g+1]));
    uvs_rot_cell u_la (.clk_i(clk_i), .step_i(5'(g)), .word_i(la_r[g]),
                       .word_o(la_r[g+1]));
    always_ff @(posedge clk_i) begin
      tu_stage_q <= tu_p[g];
      tv_stage_q <= tv_p[g];
      nlo_stage_q <= nlo_p[g];
      nla_stage_q <= nla_p[g];
    end
    assign tu_p[g+1] = tu_stage_q;
    assign tv_p[g+1] = tv_stage_q;
    assign nlo_p[g+1] = nlo_stage_q;
    assign nla_p[g+1] = nla_stage_q;
  end

  // Stage M1: trig products.
  logic signed [CwBits-1:0] co, so, cl, sl;
  assign co = nlo_p[CordicSteps] ? -lo_r[CordicSteps].x : lo_r[CordicSteps].x;
  assign so = nlo_p[CordicSteps] ? -lo_r[CordicSteps].y : lo_r[CordicSteps].y;
  assign cl = nla_p[CordicSteps] ? -la_r[CordicSteps].x : la_r[CordicSteps].x;
  assign sl = nla_p[CordicSteps] ? -la_r[CordicSteps].y : la_r[CordicSteps].y;
  logic signed [2*CwBits-1:0] pcx_q, pcy_q;
  logic signed [CwBits-1:0] sl1_q;
  logic [TexBits-1:0] tu1_q, tv1_q;
  always_ff @(posedge clk_i) begin
    pcx_q <= cl * co;
    pcy_q <= cl * so;
    sl1_q <= sl;
    tu1_q <= tu_p[CordicSteps];
    tv1_q <= tv_p[CordicSteps];
  end
  // Stage M2: rounding to Q2.30 and normals.
  function automatic logic signed [CwBits-1:0] rnd30(input logic signed [2*CwBits-1:0] v);
    logic signed [2*CwBits-1:0] t;
    t = (v + (68'sd1 <<< 29)) >>> 30;
    return t[CwBits-1:0];
  endfunction
  function automatic logic signed [NrmBits-1:0] satn(input logic signed [2*CwBits-1:0] v);
    if (v > 68'sd16384) return NrmLim;
    if (v < -68'sd16384) return -NrmLim;
    return v[NrmBits-1:0];
  endfunction
  logic signed [CwBits-1:0] px_q, py_q, sl2_q;
  logic signed [NrmBits-1:0] nx_q, ny_q, nz_q;
  logic [TexBits-1:0] tu2_q, tv2_q;
  always_ff @(posedge clk_i) begin
    px_q <= rnd30(pcx_q);
    py_q <= rnd30(pcy_q);
    sl2_q <= sl1_q;
    nx_q <= satn((pcx_q + (68'sd1 <<< 45)) >>> 46);
    ny_q <= satn((pcy_q + (68'sd1 <<< 45)) >>> 46);
    nz_q <= satn(($signed({{CwBits{sl1_q[CwBits-1]}}, sl1_q}) + 68'sd32768) >>> 16);
    tu2_q <= tu1_q;
    tv2_q <= tv1_q;
  end
  // Stage M3: radius products (34 x 17 bits).
  logic signed [2*CwBits-1:0] rx_q, ry_q, rz_q;
  logic signed [NrmBits-1:0] nx3_q, ny3_q, nz3_q;
  logic [TexBits-1:0] tu3_q, tv3_q;
  logic signed [RadBits:0] rad_s;
  assign rad_s = {1'b0, rad_q};
  always_ff @(posedge clk_i) begin
    rx_q <= px_q * rad_s;
    ry_q <= py_q * rad_s;
    rz_q <= sl2_q * rad_s;
    nx3_q <= nx_q; ny3_q <= ny_q; nz3_q <= nz_q;
    tu3_q <= tu2_q; tv3_q <= tv2_q;
  end
  function automatic logic signed [IdxBits-1:0] satp(input logic signed [2*CwBits-1:0] v);
    logic signed [2*CwBits-1:0] t;
    t = (v + (68'sd1 <<< 29)) >>> 30;
    if (t > 68'sd1048575) return PosLim;
    if (t < -68'sd1048575) return -PosLim;
    return t[IdxBits-1:0];
  endfunction

  // Stage M4: result words registered for the issue sequencer.
  typedef struct packed {
    logic                       err;
    logic                       t1;
    logic                       t2;
    logic [IdxBits-1:0]         k1;
    logic [IdxBits-1:0]         k2;
    logic signed [IdxBits-1:0]  x;
    logic signed [IdxBits-1:0]  y;
    logic signed [IdxBits-1:0]  z;
    logic signed [NrmBits-1:0]  nx;
    logic signed [NrmBits-1:0]  ny;
    logic signed [NrmBits-1:0]  nz;
    logic [TexBits-1:0]         u;
    logic [TexBits-1:0]         v;
  } vtx_t;
  vtx_t fin_q;
  side_t sd;
  assign sd = side_q[Depth-2];
  logic [IdxBits-1:0] k1_c;
  assign k1_c = IdxBits'(sd.i) * (IdxBits'(s_cnt) + 21'd1) + IdxBits'(sd.j);
  logic inner;
  assign inner = sd.i < t_cnt && sd.j < s_cnt;
  // The word is held for the whole issue window, so it only loads with a new point.
  always_ff @(posedge clk_i) begin
    if (vld_q[Depth-2]) begin
      fin_q.err <= sd.err;
      fin_q.t1 <= inner && sd.i != '0;
      fin_q.t2 <= inner && sd.i != t_cnt - 10'd1;
      fin_q.k1 <= k1_c;
      fin_q.k2 <= k1_c + IdxBits'(s_cnt) + 21'd1;
      fin_q.x <= satp(rx_q);
      fin_q.y <= satp(ry_q);
      fin_q.z <= satp(rz_q);
      fin_q.nx <= nx3_q; fin_q.ny <= ny3_q; fin_q.nz <= nz3_q;
      fin_q.u <= tu3_q; fin_q.v <= tv3_q;
    end
  end

  // Issue: vertex or error word, then up to two triangles in ph_q states 1 and 2.
  logic [1:0] ph_q;
  logic fin_v;
  assign fin_v = vld_q[Depth-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ph_q <= 2'd0;
    else if (fin_v) ph_q <= 2'd1;
    else if (ph_q != 2'd0) ph_q <= (ph_q == 2'd2) ? 2'd0 : 2'd2;
  end
  always_comb begin
    valid_o = 1'b0; kind_o = KindVertex; last_o = 1'b0;
    word_a_o = '0; word_b_o = '0; word_c_o = '0;
    normal_x_o = '0; normal_y_o = '0; normal_z_o = '0;
    tex_u_o = '0; tex_v_o = '0;
    if (fin_v) begin
      valid_o = 1'b1;
      if (fin_q.err) begin
        kind_o = KindError; last_o = 1'b1;
      end else begin
        last_o = !fin_q.t1 && !fin_q.t2;
        word_a_o = fin_q.x; word_b_o = fin_q.y; word_c_o = fin_q.z;
        normal_x_o = fin_q.nx; normal_y_o = fin_q.ny; normal_z_o = fin_q.nz;
        tex_u_o = fin_q.u; tex_v_o = fin_q.v;
      end
    end else if (ph_q == 2'd1 && !fin_q.err && fin_q.t1) begin
      valid_o = 1'b1; kind_o = KindTriangle; last_o = !fin_q.t2;
      word_a_o = fin_q.k1; word_b_o = fin_q.k2; word_c_o = fin_q.k1 + 21'd1;
    end else if (ph_q == 2'd2 && !fin_q.err && fin_q.t2) begin
      valid_o = 1'b1; kind_o = KindTriangle; last_o = 1'b1;
      word_a_o = fin_q.k1 + 21'd1; word_b_o = fin_q.k2; word_c_o = fin_q.k2 + 21'd1;
    end
  end

`ifndef ASSERT_OFF
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni) go |=> busy_o)
    else $error("start accepted inside issue window");
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == KindError) |-> last_o) else $error("error word not last");
  a_tri_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && kind_o == KindTriangle) |-> ph_q != 2'd0) else $error("stray triangle");
`endif
endmodule
`default_nettype wire
